// ===== hw/rtl/gpwa_pkg.sv =====
// ----------------------------------------------------------------------------
// Gated peak window average: shared definitions
// Field widths, port packing widths and default sizes used across the block.
// ----------------------------------------------------------------------------
package gpwa_pkg;

    // Field widths of the input and result items.
    localparam int ROW_W    = 10;
    localparam int STR_W    = 20;
    localparam int BAND_W   = 11;
    localparam int LIMIT_W  = 10;

    // One above the highest row that the block accepts as is; larger rows are clamped.
    localparam int MAX_ROWS = 1024;

    // Default number of peaks kept in the averaging window.
    localparam int WINDOW_DEFAULT = 8;

    // Packed stream widths, filled up to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

endpackage : gpwa_pkg

// ===== hw/rtl/gated_peak_window_average.sv =====
// ----------------------------------------------------------------------------
// Gated peak window average
// Keeps a sliding window of frame peaks (row and strength), gates new peaks
// against the running average row, and reports the averages and a band start.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Request contents
//  --------+-----------+--------------------+-----------------------------------
//  cfg     | in        | cfg_valid/ready    | deviation_limit (10 bits)
//  s       | in        | s_tvalid/tready    | peak_row, peak_strength
//  m       | out       | m_tvalid/tready    | averages, band start, stored flag;
//          |           |                    | tuser carries average_ready
//
// One request is taken every cycle when the result side keeps up. A request
// goes through two register stages: the accepting edge updates the window,
// the running sums and the gate flag and fills the middle stage; the result
// register is loaded from the middle stage whenever it is empty or taken.
// Reset clears the fill count, the sums and sets the gate flag; the window
// contents themselves are not cleared, as they are only read once written.
// When the result register is stalled, the middle stage holds and the input
// side stops accepting only once that stage is also occupied.
// ----------------------------------------------------------------------------
module gated_peak_window_average
    import gpwa_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LIMIT_W-1:0]   cfg_data,     // deviation_limit

    // Input peak stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // [9:0] peak_row, [29:10] peak_strength

    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,      // [9:0] average_row,
                                               // [29:10] average_strength,
                                               // [40:30] band_start, [41] stored
    output logic                 m_tuser       // [0] average_ready
);

    // ------------------------------------------------------------------------
    // Derived sizes. Division by WINDOW is a multiply by a rounded-up
    // reciprocal followed by a shift; with the shift taken as the sum width
    // plus ceil(log2(WINDOW)), the quotient is exact for every sum value.
    // ------------------------------------------------------------------------
    localparam int WL        = $clog2(WINDOW);
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int RSUM_W    = ROW_W + WL;
    localparam int SSUM_W    = STR_W + WL;
    localparam int ROW_SHIFT = RSUM_W + WL;
    localparam int STR_SHIFT = SSUM_W + WL;
    localparam longint ROW_RECIP_L =
        ((64'd1 << ROW_SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
    localparam longint STR_RECIP_L =
        ((64'd1 << STR_SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
    localparam logic [RSUM_W:0] ROW_RECIP = ROW_RECIP_L[RSUM_W:0];
    localparam logic [SSUM_W:0] STR_RECIP = STR_RECIP_L[SSUM_W:0];
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_ROWS - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

    // ------------------------------------------------------------------------
    // Configuration register. Writes are expected only while the block is
    // idle.
    // ------------------------------------------------------------------------
    logic [LIMIT_W-1:0] limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------------
    // Stage control. The middle stage holds one request whose window update
    // is already done; the result register holds one finished result.
    // ------------------------------------------------------------------------
    logic mid_valid_reg;
    logic out_valid_reg;
    logic out_advance;
    logic in_accept;

    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready    = !mid_valid_reg || out_advance;
    assign in_accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // Window state. The window is a shift line: a stored peak enters at tap
    // zero, so once the window is full the oldest entry sits at the last tap.
    // ------------------------------------------------------------------------
    logic [ROW_W-1:0]  row_line_reg [WINDOW];
    logic [STR_W-1:0]  str_line_reg [WINDOW];
    logic [FILL_W-1:0] fill_reg;
    logic [RSUM_W-1:0] row_sum_reg;
    logic [SSUM_W-1:0] str_sum_reg;
    logic              within_reg;

    logic [FILL_W-1:0] fill_next;
    logic [RSUM_W-1:0] row_sum_next;
    logic [SSUM_W-1:0] str_sum_next;
    logic              within_next;

    // Incoming request fields.
    logic [ROW_W-1:0] in_row;
    logic [STR_W-1:0] in_str;
    logic [ROW_W-1:0] row_clamped;

    assign in_row = s_tdata[ROW_W-1:0];
    assign in_str = s_tdata[ROW_W +: STR_W];
    assign row_clamped = (in_row > ROW_LIMIT) ? ROW_LIMIT : in_row;

    // The average row held from the last full result always equals the
    // current row sum divided by the window, since the sum only moves on a
    // store and every store into a full window leaves it full.
    logic                      win_full;
    logic [2*RSUM_W:0]         held_prod;
    logic [ROW_W-1:0]          held_avg;
    logic [ROW_W-1:0]          row_gap;
    logic                      in_limit;
    logic                      push;
    logic [ROW_W-1:0]          drop_row;
    logic [STR_W-1:0]          drop_str;

    assign win_full  = (fill_reg == FILL_FULL);
    assign held_prod = (2*RSUM_W+1)'(row_sum_reg) * (2*RSUM_W+1)'(ROW_RECIP);
    assign held_avg  = held_prod[ROW_SHIFT +: ROW_W];
    assign row_gap   = (held_avg > row_clamped) ? (held_avg - row_clamped)
                                                : (row_clamped - held_avg);
    assign in_limit  = (row_gap <= limit_reg);
    assign push      = (row_clamped != '0) && (!win_full || in_limit);
    assign drop_row  = win_full ? row_line_reg[WINDOW-1] : '0;
    assign drop_str  = win_full ? str_line_reg[WINDOW-1] : '0;

    always_comb
    begin
        fill_next    = fill_reg;
        row_sum_next = row_sum_reg;
        str_sum_next = str_sum_reg;
        within_next  = within_reg;
        if (push)
        begin
            row_sum_next = row_sum_reg + RSUM_W'(row_clamped) - RSUM_W'(drop_row);
            str_sum_next = str_sum_reg + SSUM_W'(in_str) - SSUM_W'(drop_str);
            if (!win_full)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        // The gate flag only changes for a nonzero row against a full window.
        if ((row_clamped != '0) && win_full)
        begin
            within_next = in_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            row_sum_reg <= '0;
            str_sum_reg <= '0;
            within_reg  <= 1'b1;
        end
        else if (in_accept)
        begin
            fill_reg    <= fill_next;
            row_sum_reg <= row_sum_next;
            str_sum_reg <= str_sum_next;
            within_reg  <= within_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && push)
        begin
            row_line_reg[0] <= row_clamped;
            str_line_reg[0] <= in_str;
            for (int i = 1; i < WINDOW; i++)
            begin
                row_line_reg[i] <= row_line_reg[i-1];
                str_line_reg[i] <= str_line_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Middle stage: the request's row and stored flag wait here while the
    // state registers already reflect its update.
    // ------------------------------------------------------------------------
    logic [ROW_W-1:0] mid_row_reg;
    logic             mid_stored_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            mid_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mid_row_reg    <= row_clamped;
            mid_stored_reg <= push;
        end
    end

    // ------------------------------------------------------------------------
    // Result stage: averages from the updated sums and the band start.
    // The band base is the peak row while the gate flag is set, otherwise
    // the average row; half the limit is taken off in 11-bit two's complement.
    // ------------------------------------------------------------------------
    logic [2*RSUM_W:0] avg_row_prod;
    logic [2*SSUM_W:0] avg_str_prod;
    logic [ROW_W-1:0]  avg_row;
    logic [STR_W-1:0]  avg_str;
    logic [ROW_W-1:0]  band_base;
    logic [BAND_W-1:0] band;

    assign avg_row_prod = (2*RSUM_W+1)'(row_sum_reg) * (2*RSUM_W+1)'(ROW_RECIP);
    assign avg_str_prod = (2*SSUM_W+1)'(str_sum_reg) * (2*SSUM_W+1)'(STR_RECIP);
    assign avg_row      = avg_row_prod[ROW_SHIFT +: ROW_W];
    assign avg_str      = avg_str_prod[STR_SHIFT +: STR_W];
    assign band_base    = within_reg ? mid_row_reg : avg_row;
    assign band         = BAND_W'(band_base) - BAND_W'(limit_reg[LIMIT_W-1:1]);

    logic              out_ready_flag_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [STR_W-1:0]  out_str_reg;
    logic [BAND_W-1:0] out_band_reg;
    logic              out_stored_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && mid_valid_reg)
        begin
            out_ready_flag_reg <= win_full;
            out_row_reg        <= win_full ? avg_row : '0;
            out_str_reg        <= win_full ? avg_str : '0;
            out_band_reg       <= win_full ? band : '0;
            out_stored_reg     <= mid_stored_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ready_flag_reg;
    assign m_tdata  = {(M_TDATA_W-ROW_W-STR_W-BAND_W-1)'(0), out_stored_reg,
                       out_band_reg, out_str_reg, out_row_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond window size");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && push && !win_full |=> fill_reg == $past(fill_reg) + FILL_W'(1))
        else $error("store into a filling window did not grow the fill count");

    a_stored_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg && mid_stored_reg |-> mid_row_reg != '0)
        else $error("a row of zero was stored");

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> out_row_reg == '0 && out_str_reg == '0
                                 && out_band_reg == '0)
        else $error("result fields set while the window is not full");

endmodule : gated_peak_window_average

// ===== test/gated_peak_window_average_test.sv =====
// ----------------------------------------------------------------------------
// Gated peak window average: self-checking stream testbench
// Drives peak requests and deviation limit writes into the block, predicts
// every result with an independent model of the gated window, and compares
// each result field by field under random idling and stalls on both sides.
// ----------------------------------------------------------------------------
module gated_peak_window_average_test;

    import gpwa_pkg::*;

    localparam int WINDOW       = WINDOW_DEFAULT;
    localparam int SLOT_W       = $clog2(WINDOW);
    localparam int ROW_SUM_W    = ROW_W + SLOT_W;
    localparam int STR_SUM_W    = STR_W + SLOT_W;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 4;
    // The block is two register stages deep; the settle wait covers it.
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 48;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 235;
    // The limit sits well above the slowest correct run, even if every
    // request waits out the longest gap on both sides.
    localparam int CYCLE_LIMIT   = 600000;

    // One result request, in the order the fields are listed for the block.
    typedef struct packed {
        logic              ready;
        logic [ROW_W-1:0]  avg_row;
        logic [STR_W-1:0]  avg_str;
        logic [BAND_W-1:0] band;
        logic              stored;
    } avg_result_t;

    typedef enum logic [0:0] {
        STEP_PEAK,
        STEP_LIMIT
    } step_kind_t;

    // A directed row either offers a peak or writes the deviation limit
    // (the value then sits in the row column).
    typedef struct {
        step_kind_t        kind;
        logic [ROW_W-1:0]  row;
        logic [STR_W-1:0]  strength;
        bit                typed;
        avg_result_t       want;
    } directed_step_t;

    localparam logic [STR_W-1:0] STR_MAX = '1;
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_ROWS - 1);

    // Results that can be read off directly: an ignored peak before the
    // window is full, a stored peak while filling, and the first full window.
    localparam avg_result_t IGNORED_EMPTY = '0;
    localparam avg_result_t FILL_STORED   = '{1'b0, '0, '0, '0, 1'b1};
    localparam avg_result_t FULL_AT_MAX   = '{1'b1, ROW_MAX, STR_MAX,
                                              BAND_W'(ROW_MAX), 1'b1};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [LIMIT_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Model of the block state, updated once per accepted peak request.
    logic [ROW_W-1:0]     row_slots [WINDOW];
    logic [STR_W-1:0]     strength_slots [WINDOW];
    int                   kept_count;
    int                   oldest_slot;
    logic [ROW_SUM_W-1:0] row_total;
    logic [STR_SUM_W-1:0] strength_total;
    logic [ROW_W-1:0]     held_avg_row;
    logic                 peak_in_gate;
    logic [LIMIT_W-1:0]   gate_limit;

    avg_result_t pending_averages [$];
    int          failures;
    int          cycle_count;
    bit          no_idle;
    bit          long_hold_request;

    directed_step_t plan [23] = '{
        // Row zero before any peak is simply dropped.
        '{STEP_PEAK,  10'd0,    STR_MAX, 1'b1, IGNORED_EMPTY},
        // Fill the window with the largest row and strength.
        '{STEP_PEAK,  ROW_MAX,  STR_MAX, 1'b1, FILL_STORED},
        '{STEP_PEAK,  ROW_MAX,  STR_MAX, 1'b1, FILL_STORED},
        '{STEP_PEAK,  ROW_MAX,  STR_MAX, 1'b1, FILL_STORED},
        '{STEP_PEAK,  ROW_MAX,  STR_MAX, 1'b1, FILL_STORED},
        '{STEP_PEAK,  ROW_MAX,  STR_MAX, 1'b1, FILL_STORED},
        '{STEP_PEAK,  ROW_MAX,  STR_MAX, 1'b1, FILL_STORED},
        '{STEP_PEAK,  ROW_MAX,  STR_MAX, 1'b1, FILL_STORED},
        '{STEP_PEAK,  ROW_MAX,  STR_MAX, 1'b1, FULL_AT_MAX},
        // Limit zero: an equal row passes, a distant row is gated out, and
        // a following row zero keeps the gate closed.
        '{STEP_PEAK,  ROW_MAX,  20'd0,   1'b0, '0},
        '{STEP_PEAK,  10'd1,    20'd1,   1'b0, '0},
        '{STEP_PEAK,  10'd0,    20'd5,   1'b0, '0},
        '{STEP_PEAK,  ROW_MAX,  20'd12345, 1'b0, '0},
        // Widest limit: every row passes and the band start goes negative.
        '{STEP_LIMIT, 10'd1023, 20'd0,   1'b0, '0},
        '{STEP_PEAK,  10'd1,    20'd0,   1'b0, '0},
        '{STEP_PEAK,  10'd1,    20'd0,   1'b0, '0},
        '{STEP_PEAK,  10'd1,    20'd0,   1'b0, '0},
        '{STEP_PEAK,  10'd1,    20'd0,   1'b0, '0},
        '{STEP_PEAK,  10'd0,    20'd0,   1'b0, '0},
        // Limit one: a row at the edge passes, a row beyond is rejected.
        '{STEP_LIMIT, 10'd1,    20'd0,   1'b0, '0},
        '{STEP_PEAK,  10'd513,  STR_MAX, 1'b0, '0},
        '{STEP_PEAK,  10'd600,  20'd1,   1'b0, '0},
        '{STEP_PEAK,  10'd0,    20'd0,   1'b0, '0}
    };

    gated_peak_window_average u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Gated window update for one accepted peak request. While the window
    // fills, every nonzero row goes in; afterwards a row must lie within the
    // limit of the last reported average row, and it then replaces the
    // oldest entry. The gate flag is only touched by a nonzero row once the
    // window is full.
    function automatic avg_result_t gate_peak(input logic [ROW_W-1:0] row,
                                              input logic [STR_W-1:0] strength);
        avg_result_t      res;
        logic [ROW_W-1:0] row_gap;
        logic [ROW_W-1:0] base;
        int               slot;

        res = '0;
        if (row != '0)
        begin
            if (kept_count < WINDOW)
            begin
                slot = (oldest_slot + kept_count) % WINDOW;
                row_slots[slot]      = row;
                strength_slots[slot] = strength;
                row_total      = row_total + row;
                strength_total = strength_total + strength;
                kept_count++;
                res.stored = 1'b1;
            end
            else
            begin
                row_gap = (held_avg_row > row) ? held_avg_row - row : row - held_avg_row;
                peak_in_gate = (row_gap <= gate_limit);
                if (peak_in_gate)
                begin
                    row_total      = row_total - row_slots[oldest_slot] + row;
                    strength_total = strength_total - strength_slots[oldest_slot]
                                     + strength;
                    row_slots[oldest_slot]      = row;
                    strength_slots[oldest_slot] = strength;
                    oldest_slot = (oldest_slot + 1) % WINDOW;
                    res.stored = 1'b1;
                end
            end
        end

        if (kept_count == WINDOW)
        begin
            res.ready   = 1'b1;
            res.avg_row = ROW_W'(row_total / WINDOW);
            res.avg_str = STR_W'(strength_total / WINDOW);
            base        = peak_in_gate ? row : res.avg_row;
            // The subtraction wraps at the band width, giving two's complement.
            res.band    = {1'b0, base} - {2'b0, gate_limit[LIMIT_W-1:1]};
            held_avg_row = res.avg_row;
        end
        return res;
    endfunction

    // Mostly short gaps, now and then a long one, none during quiet stretches.
    function automatic int idle_length();
        int pick;

        pick = $urandom_range(0, 99);
        if (no_idle || pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Offers one peak request from a falling edge and returns at a falling
    // edge after it was taken, once a random idle gap has passed.
    task automatic offer_peak(input logic [ROW_W-1:0] row,
                              input logic [STR_W-1:0] strength,
                              input bit typed, input avg_result_t want);
        avg_result_t predicted;
        int          gap;

        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - ROW_W - STR_W){1'b0}}, strength, row};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = gate_peak(row, strength);
        pending_averages.insert(pending_averages.size(), typed ? want : predicted);
        @(negedge clk);
        gap = idle_length();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_averages.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The block is idle here, so the limit can change safely.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        gate_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // Result checker: every result request taken at a rising edge is matched
    // against the oldest prediction still waiting.
    always @(posedge clk)
    begin
        avg_result_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_averages.size() == 0)
            begin
                failures++;
                $display("%0t: result with no expectation, actual tdata 0x%0h tuser %0b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = pending_averages.pop_front();
                compare_field("average_ready", want.ready, m_tuser);
                compare_field("average_row", want.avg_row, m_tdata[9:0]);
                compare_field("average_strength", want.avg_str, m_tdata[29:10]);
                compare_field("band_start", want.band, m_tdata[40:30]);
                compare_field("stored", want.stored, m_tdata[41]);
            end
        end
    end

    // Result receiver. Random stalls, plus one long hold-off on request that
    // lets the block fill up and push back on the peak stream.
    initial
    begin : result_sink
        int stall;

        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_request)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_request = 1'b0;
            end
            else
            begin
                stall = idle_length();
                if (stall != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [LIMIT_W-1:0] limit;
        logic [ROW_W-1:0]   row;
        logic [STR_W-1:0]   strength;
        int                 pick;
        int                 spread;
        int                 near;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        failures  = 0;
        no_idle   = 1'b0;
        long_hold_request = 1'b0;

        kept_count     = 0;
        oldest_slot    = 0;
        row_total      = '0;
        strength_total = '0;
        held_avg_row   = '0;
        peak_in_gate   = 1'b1;
        gate_limit     = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset limit of zero.
        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_LIMIT)
            begin
                wait_for_results();
                write_limit(plan[i].row);
            end
            else
            begin
                offer_peak(plan[i].row, plan[i].strength, plan[i].typed, plan[i].want);
            end
        end

        // Random part: one limit per phase, the extremes first. Most rows sit
        // around the last average so that the gate both opens and closes.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: limit = '0;
                1: limit = '1;
                2: limit = 10'd1;
                3: limit = 10'd511;
                default: limit = LIMIT_W'($urandom_range(0, (1 << LIMIT_W) - 1));
            endcase
            wait_for_results();
            write_limit(limit);

            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                // Quiet stretches with no idling on either side.
                no_idle = (phase % 2 == 1 && item < 40);

                // Hold the receiver off while peaks keep coming back to back.
                if (phase == 1 && item == 60)
                    long_hold_request = 1'b1;
                if (phase == 1 && item >= 60 && item < 140)
                    no_idle = 1'b1;

                // Let everything drain once in the middle of a phase.
                if (phase == 2 && item == 120)
                    wait_for_results();

                pick = $urandom_range(0, 99);
                if (pick < 8)
                    row = '0;
                else if (pick < 18 || kept_count < WINDOW)
                    row = ROW_W'($urandom_range(1, MAX_ROWS - 1));
                else
                begin
                    spread = int'(gate_limit) + 2;
                    near = int'(held_avg_row) + int'($urandom_range(0, 2 * spread)) - spread;
                    if (near < 1)
                        near = 1;
                    if (near > MAX_ROWS - 1)
                        near = MAX_ROWS - 1;
                    row = ROW_W'(near);
                end

                pick = $urandom_range(0, 99);
                if (pick < 10)
                    strength = '0;
                else if (pick < 20)
                    strength = STR_MAX;
                else
                    strength = STR_W'($urandom_range(0, (1 << STR_W) - 1));

                offer_peak(row, strength, 1'b0, '0);
            end
        end

        no_idle = 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
